// ===== rtl/core/cist_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cist_pkg
// Shared types and constants for the compacting identifier set table.
// ----------------------------------------------------------------------------
package cist_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 32;
    localparam int SLOT_W   = 6;
    localparam int POS_W    = 6;
    localparam int OCNT_W   = 7;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 48;

    localparam logic [ID_W-1:0] NO_ID = '1;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SHIFT,
        ST_READ,
        ST_DONE
    } t_state;

    // input word, slot_index in the top bits, cmd in the lowest
    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic [ID_W-1:0]   item_id;
        t_cmd              cmd;
    } t_in_word;

    // result word, status in the lowest bit
    typedef struct packed {
        logic [OCNT_W-1:0] entry_count;
        logic [ID_W-1:0]   read_id;
        logic [POS_W-1:0]  found_position;
        logic              found;
        logic              status;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/cist_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cist_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_wr_en,
    input  wire logic [AW-1:0]          i_wr_addr,
    input  wire logic [WIDTH-1:0]       i_wr_data,
    input  wire logic [AW-1:0]          i_rd_addr,
    output logic      [WIDTH-1:0]       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== rtl/core/cist_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cist_ctrl
// Command sequencer: one shared identifier comparator walks the store,
// then the same read port feeds a compaction pass for delete.
// ----------------------------------------------------------------------------
module cist_ctrl
    import cist_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_word i_in_word,
    output logic          o_res_valid,
    input  wire logic     i_res_ready,
    output t_result       o_res
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    t_cmd               r_cmd, n_cmd;
    logic [ID_W-1:0]    r_key, n_key;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [CNT_W-1:0]   r_ptr, n_ptr;
    logic               r_pend, n_pend;
    logic [ADDR_W-1:0]  r_pend_addr, n_pend_addr;
    logic               r_status, n_status;
    logic               r_found, n_found;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [ID_W-1:0]    r_rid, n_rid;

    logic               w_wr_en;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [ID_W-1:0]    w_wr_data;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [ID_W-1:0]    w_rd_data;
    logic               w_hit;
    logic               w_issue;

    cist_ram #(
        .WIDTH (ID_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // shared compare: data read last cycle against the key
    assign w_hit   = r_pend && (w_rd_data == r_key);
    assign w_issue = (r_ptr < r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_key       <= n_key;
        r_slot      <= n_slot;
        r_ptr       <= n_ptr;
        r_pend_addr <= n_pend_addr;
        r_status    <= n_status;
        r_found     <= n_found;
        r_pos       <= n_pos;
        r_rid       <= n_rid;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_slot      = r_slot;
        n_ptr       = r_ptr;
        n_pend      = 1'b0;
        n_pend_addr = r_ptr[ADDR_W-1:0];
        n_status    = r_status;
        n_found     = r_found;
        n_pos       = r_pos;
        n_rid       = r_rid;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_count[ADDR_W-1:0];
        w_wr_data   = r_key;
        w_rd_addr   = r_ptr[ADDR_W-1:0];
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd    = i_in_word.cmd;
                    n_key    = i_in_word.item_id;
                    n_slot   = i_in_word.slot_index;
                    n_status = 1'b1;
                    n_found  = 1'b0;
                    n_pos    = '0;
                    n_rid    = NO_ID;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_cmd)
                    CMD_APPEND: begin
                        if (r_key != NO_ID && r_count < CNT_W'(CAPACITY)) begin
                            w_wr_en  = 1'b1;
                            n_count  = r_count + CNT_W'(1);
                            n_status = 1'b0;
                        end
                        n_state = ST_DONE;
                    end
                    CMD_READ: begin
                        w_rd_addr = r_slot[ADDR_W-1:0];
                        if (OCNT_W'(r_slot) < OCNT_W'(r_count)) begin
                            n_state = ST_READ;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    default: begin
                        if (r_key == NO_ID || r_count == '0) begin
                            n_state = ST_DONE;
                        end else begin
                            n_ptr   = '0;
                            n_state = ST_SCAN;
                        end
                    end
                endcase
            end
            ST_SCAN: begin
                if (w_issue) begin
                    n_pend = 1'b1;
                    n_ptr  = r_ptr + CNT_W'(1);
                end
                if (w_hit) begin
                    n_pos  = POS_W'(r_pend_addr);
                    n_pend = 1'b0;
                    if (r_cmd == CMD_FIND) begin
                        n_found  = 1'b1;
                        n_status = 1'b0;
                        n_state  = ST_DONE;
                    end else begin
                        // pull entries above the match down by one
                        n_ptr   = CNT_W'(r_pend_addr) + CNT_W'(1);
                        n_state = ST_SHIFT;
                    end
                end else if (!w_issue && !r_pend) begin
                    n_state = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (w_issue) begin
                    n_pend = 1'b1;
                    n_ptr  = r_ptr + CNT_W'(1);
                end
                if (r_pend) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_pend_addr - ADDR_W'(1);
                    w_wr_data = w_rd_data;
                end
                if (!w_issue && !r_pend) begin
                    n_pos    = '0;
                    n_count  = r_count - CNT_W'(1);
                    n_status = 1'b0;
                    n_state  = ST_DONE;
                end
            end
            ST_READ: begin
                n_rid    = w_rd_data;
                n_status = 1'b0;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.status         = r_status;
        o_res.found          = r_found;
        o_res.found_position = r_found ? r_pos : '0;
        o_res.read_id        = r_rid;
        o_res.entry_count    = OCNT_W'(r_count);
    end

endmodule
`default_nettype wire

// ===== rtl/core/compacting_id_set_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compacting_id_set_table
// Packed list of identifiers with append, delete, find and read commands.
// ----------------------------------------------------------------------------
// One command is taken at a time; s_axis_tready is low while it runs. Append
// and a command rejected before any store access go straight from the
// execute state to the result, read passes through a read state, find
// scans the entries up to the match, and delete scans up to the match and
// then compacts the entries above it. The next command is accepted once
// its result has been handed to the output register. The scan runs
// through the single read port of the identifier store, which delivers
// one entry per cycle to the one shared comparator.
// The store needs no clearing pass: entries above the count are never
// returned. A finished result waits in the output register while the next
// command is accepted.
// ----------------------------------------------------------------------------
module compacting_id_set_table
    import cist_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // cmd[1:0], item_id[33:2], slot_index[39:34]
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // status[0], found[1], found_position[7:2], read_id[39:8],
    // entry_count[46:40], zero pad[47]
    output logic      [OUT_W-1:0] m_axis_tdata
);

    t_result w_res;
    logic    w_res_valid;
    logic    w_res_ready;
    logic    r_out_vld;
    t_result r_out;

    cist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_word   (t_in_word'(s_axis_tdata)),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // load a new word when the register is empty or drains this cycle
    assign w_res_ready = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_ready) begin
            r_out_vld <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out};

endmodule
`default_nettype wire

// ===== rtl/core/cist_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cist_chk
// Port-level checks for the compacting identifier set table.
// ----------------------------------------------------------------------------
module cist_chk
    import cist_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    input  wire logic             s_axis_tready,
    input  wire logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    input  wire logic [OUT_W-1:0] m_axis_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // one command at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a command is running");

    // a found position lies inside the live entries
    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |->
            !m_axis_tdata[0] && (OCNT_W'(m_axis_tdata[7:2]) < m_axis_tdata[46:40]))
        else $error("found position outside live entries");

    // count never exceeds the table size
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[46:40] <= OCNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // reset leaves no result pending and the input open
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("bad state after reset");

endmodule

bind compacting_id_set_table cist_chk u_cist_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
